// ===== rtl/dmm_pkg.sv =====
package dmm_pkg;

	localparam int DEF_MAX_DIM   = 8;
	localparam int DEF_FRAC_BITS = 16;

	localparam int OP_W      = 2;
	localparam int IDX_W     = 3;
	localparam int VAL_W     = 32;
	localparam int DIM_W     = 4;
	localparam int CFG_IDX_W = 2;

	localparam int CQ_DEPTH = 4;
	localparam int RQ_DEPTH = 8;
	// One result in each of the three pipeline stages plus the one being issued.
	localparam int RQ_SLACK = 4;

	localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd2;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	typedef enum logic [1:0] {
		CMD_WRITE_A,
		CMD_WRITE_B,
		CMD_RUN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [DIM_W-1:0] m;
		logic [DIM_W-1:0] n;
		logic [DIM_W-1:0] q;
	} dims_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             sat;
		logic             last;
	} res_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
			input logic [DIM_W-1:0] max_dim);
		logic [DIM_W-1:0] d;
		d = r;
		if (r == '0) begin
			d = DIM_W'(1);
		end else if (r > max_dim) begin
			d = max_dim;
		end
		return d;
	endfunction

endpackage

// ===== rtl/dense_matrix_multiply.sv =====
// Dense matrix multiplier for C = A * B on signed Q16.16 elements, with A, B
// and C up to MAX_DIM by MAX_DIM. Write requests (op 0 for A, op 1 for B) go
// into a four-entry request queue and are taken at one per cycle while the
// back end is idle; writes that fall outside the configured sizes, and op 3,
// are dropped. A compute request (op 2) walks the stores with a single
// multiply-accumulate unit that reads one A and one B element per cycle while
// the result queue has room; requests behind it wait in the queue. Results are
// emitted in row-major order through an eight-entry result queue, and the
// walk pauses whenever that queue cannot take every result in flight. Each
// element is the exact sum floored to FRAC_BITS fraction bits and clipped to
// 32 bits with the saturated flag set. Store entries hold no value until
// written and there is no clearing pass after reset. Size registers are to be
// written only while the block is idle; the block itself does not enforce
// this; 0 acts as 1 and values above MAX_DIM act as MAX_DIM.
module dense_matrix_multiply import dmm_pkg::*; #(
	parameter int MAX_DIM   = DEF_MAX_DIM,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [OP_W-1:0]         op,
	input  logic [IDX_W-1:0]        row_index,
	input  logic [IDX_W-1:0]        col_index,
	input  logic signed [VAL_W-1:0] element_value,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [VAL_W-1:0] product_value,
	output logic [IDX_W-1:0]        out_row,
	output logic [IDX_W-1:0]        out_col,
	output logic                    saturated,
	output logic                    last_element,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [DIM_W-1:0]        cfg_data
);

	logic [DIM_W-1:0] a_rows_q;
	logic [DIM_W-1:0] inner_dim_q;
	logic [DIM_W-1:0] b_cols_q;
	dims_t            dims;
	logic             cq_valid;
	logic             cq_pop;
	cmd_t             cq_head;
	logic             rq_room;
	logic             res_push;
	res_t             res;
	res_t             res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q    <= DIM_RESET;
			inner_dim_q <= DIM_RESET;
			b_cols_q    <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_A_ROWS:    a_rows_q    <= cfg_data;
				CFG_INNER_DIM: inner_dim_q <= cfg_data;
				CFG_B_COLS:    b_cols_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign dims.m = eff_dim(a_rows_q, DIM_W'(MAX_DIM));
	assign dims.n = eff_dim(inner_dim_q, DIM_W'(MAX_DIM));
	assign dims.q = eff_dim(b_cols_q, DIM_W'(MAX_DIM));

	dmm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.op           (op),
		.row_index    (row_index),
		.col_index    (col_index),
		.element_value(element_value),
		.dims         (dims),
		.cq_pop       (cq_pop),
		.cq_valid     (cq_valid),
		.cq_head      (cq_head)
	);

	dmm_back #(
		.MAX_DIM  (MAX_DIM),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.dims    (dims),
		.cq_valid(cq_valid),
		.cq_head (cq_head),
		.cq_pop  (cq_pop),
		.rq_room (rq_room),
		.res_push(res_push),
		.res     (res)
	);

	dmm_rq u_rq (
		.clk     (clk),
		.arst_n  (arst_n),
		.res_push(res_push),
		.res_in  (res),
		.rq_room (rq_room),
		.empty   (empty),
		.pop     (pop),
		.res_out (res_out)
	);

	assign product_value = $signed(res_out.value);
	assign out_row       = res_out.row;
	assign out_col       = res_out.col;
	assign saturated     = res_out.sat;
	assign last_element  = res_out.last;

endmodule

// ===== rtl/dmm_ram.sv =====
module dmm_ram import dmm_pkg::*; #(
	parameter int WIDTH = VAL_W,
	parameter int DEPTH = DEF_MAX_DIM * DEF_MAX_DIM
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/dmm_front.sv =====
module dmm_front import dmm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [OP_W-1:0]         op,
	input  logic [IDX_W-1:0]        row_index,
	input  logic [IDX_W-1:0]        col_index,
	input  logic signed [VAL_W-1:0] element_value,
	input  dims_t                   dims,
	input  logic                    cq_pop,
	output logic                    cq_valid,
	output cmd_t                    cq_head
);

	localparam int PW = $clog2(CQ_DEPTH);
	localparam int CW = $clog2(CQ_DEPTH + 1);

	cmd_t          cq_mem [CQ_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	cmd_t          cmd;
	logic          keep;
	logic          wr;
	logic          rd;
	logic [DIM_W-1:0] row_w;
	logic [DIM_W-1:0] col_w;

	assign row_w = DIM_W'(row_index);
	assign col_w = DIM_W'(col_index);

	always_comb begin
		cmd.kind  = CMD_RUN;
		cmd.row   = row_index;
		cmd.col   = col_index;
		cmd.value = element_value;
		keep      = 1'b0;
		case (op)
			OP_WRITE_A: begin
				cmd.kind = CMD_WRITE_A;
				keep     = (row_w < dims.m) && (col_w < dims.n);
			end
			OP_WRITE_B: begin
				cmd.kind = CMD_WRITE_B;
				keep     = (row_w < dims.n) && (col_w < dims.q);
			end
			OP_COMPUTE: begin
				cmd.kind = CMD_RUN;
				keep     = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full     = (count_q == CW'(CQ_DEPTH));
	assign cq_valid = (count_q != '0);
	assign cq_head  = cq_mem[rd_q];
	assign wr       = push && !full && keep;
	assign rd       = cq_pop && cq_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			cq_mem[wr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wr_q <= (wr_q == PW'(CQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd) begin
				rd_q <= (rd_q == PW'(CQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_cq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CQ_DEPTH))
		else $error("Request queue count beyond its depth.");

endmodule

// ===== rtl/dmm_back.sv =====
module dmm_back import dmm_pkg::*; #(
	parameter int MAX_DIM   = DEF_MAX_DIM,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  dims_t dims,
	input  logic  cq_valid,
	input  cmd_t  cq_head,
	output logic  cq_pop,
	input  logic  rq_room,
	output logic  res_push,
	output res_t  res
);

	localparam int IW    = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = 2 * VAL_W;
	localparam int ACC_W = PW + IW + 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} back_state_t;

	back_state_t state_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] k_q;

	logic          a_we;
	logic          b_we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;
	logic [VAL_W-1:0] a_rd;
	logic [VAL_W-1:0] b_rd;
	logic          issue;
	logic          i_last;
	logic          j_last;
	logic          k_last;

	logic          v_s1;
	logic          first_s1;
	logic          last_s1;
	logic          fin_s1;
	logic [IW-1:0] i_s1;
	logic [IW-1:0] j_s1;

	logic                 v_s2;
	logic                 first_s2;
	logic                 last_s2;
	logic                 fin_s2;
	logic [IW-1:0]        i_s2;
	logic [IW-1:0]        j_s2;
	logic signed [PW-1:0] prod_s2;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] sum;

	logic                    v_s3;
	logic                    fin_s3;
	logic [IW-1:0]           i_s3;
	logic [IW-1:0]           j_s3;
	logic signed [ACC_W-1:0] sum_s3;
	logic signed [ACC_W-1:0] shifted;
	logic                    fits;

	assign cq_pop = (state_q == ST_IDLE) && cq_valid;
	assign a_we   = cq_pop && (cq_head.kind == CMD_WRITE_A);
	assign b_we   = cq_pop && (cq_head.kind == CMD_WRITE_B);
	assign waddr  = AW'(int'(cq_head.row) * MAX_DIM + int'(cq_head.col));

	assign issue   = (state_q == ST_RUN) && rq_room;
	assign k_last  = (DIM_W'(k_q) + DIM_W'(1)) == dims.n;
	assign j_last  = (DIM_W'(j_q) + DIM_W'(1)) == dims.q;
	assign i_last  = (DIM_W'(i_q) + DIM_W'(1)) == dims.m;
	assign raddr_a = AW'(int'(i_q) * MAX_DIM + int'(k_q));
	assign raddr_b = AW'(int'(k_q) * MAX_DIM + int'(j_q));

	dmm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_left (
		.clk  (clk),
		.we   (a_we),
		.waddr(waddr),
		.wdata(cq_head.value),
		.raddr(raddr_a),
		.rdata(a_rd)
	);

	dmm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_right (
		.clk  (clk),
		.we   (b_we),
		.waddr(waddr),
		.wdata(cq_head.value),
		.raddr(raddr_b),
		.rdata(b_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cq_pop && (cq_head.kind == CMD_RUN)) begin
						state_q <= ST_RUN;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_RUN: begin
					if (issue) begin
						if (k_last) begin
							k_q <= '0;
							if (j_last) begin
								j_q <= '0;
								if (i_last) begin
									i_q     <= '0;
									state_q <= ST_IDLE;
								end else begin
									i_q <= i_q + 1'b1;
								end
							end else begin
								j_q <= j_q + 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && last_s2;
		end
	end

	assign sum = (first_s2 ? ACC_W'(0) : acc_q) + ACC_W'(prod_s2);

	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		last_s1  <= k_last;
		fin_s1   <= i_last && j_last;
		i_s1     <= i_q;
		j_s1     <= j_q;

		first_s2 <= first_s1;
		last_s2  <= last_s1;
		fin_s2   <= fin_s1;
		i_s2     <= i_s1;
		j_s2     <= j_s1;
		prod_s2  <= $signed(a_rd) * $signed(b_rd);

		if (v_s2) begin
			acc_q <= sum;
		end
		if (v_s2 && last_s2) begin
			sum_s3 <= sum;
			fin_s3 <= fin_s2;
			i_s3   <= i_s2;
			j_s3   <= j_s2;
		end
	end

	// Flooring to the fraction width is an arithmetic shift of the exact sum.
	assign shifted = sum_s3 >>> FRAC_BITS;
	assign fits    = (&shifted[ACC_W-1:VAL_W-1]) || !(|shifted[ACC_W-1:VAL_W-1]);

	always_comb begin
		res.row  = IDX_W'(i_s3);
		res.col  = IDX_W'(j_s3);
		res.last = fin_s3;
		res.sat  = !fits;
		if (fits) begin
			res.value = shifted[VAL_W-1:0];
		end else if (sum_s3[ACC_W-1]) begin
			res.value = {1'b1, {(VAL_W - 1){1'b0}}};
		end else begin
			res.value = {1'b0, {(VAL_W - 1){1'b1}}};
		end
	end

	assign res_push = v_s3;

	a_s3_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> $past(v_s2 && last_s2))
		else $error("Result produced without a completed accumulation.");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && fin_s1 && last_s1) |-> (state_q == ST_IDLE))
		else $error("Sequencer still running after its final read.");

	a_no_issue_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> !issue)
		else $error("Store write and product read requested together.");

endmodule

// ===== rtl/dmm_rq.sv =====
module dmm_rq import dmm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic res_push,
	input  res_t res_in,
	output logic rq_room,
	output logic empty,
	input  logic pop,
	output res_t res_out
);

	localparam int PW = $clog2(RQ_DEPTH);
	localparam int CW = $clog2(RQ_DEPTH + 1);

	res_t          rq_mem [RQ_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          rd;

	assign empty   = (count_q == '0);
	assign rd      = pop && !empty;
	assign rq_room = (count_q <= CW'(RQ_DEPTH - RQ_SLACK));
	assign res_out = rq_mem[rd_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			rq_mem[wr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (res_push) begin
				wr_q <= (wr_q == PW'(RQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd) begin
				rd_q <= (rd_q == PW'(RQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (res_push && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !res_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_rq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (count_q != CW'(RQ_DEPTH)))
		else $error("Result written into a full result queue.");

endmodule
